### hdl/spdot_pkg.sv
// ----------------------------------------------------------------------------
// spdot_pkg
// types, codes and defaults shared by the sparse dot product block
// ----------------------------------------------------------------------------
package spdot_pkg;

  localparam int unsigned DefMaxEntries = 256;
  localparam int unsigned DefIndexRange = 1024;

  localparam int unsigned IndexWidth = 10;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SumWidth   = 64;

  localparam logic [1:0] MODE_LOAD_ROW = 2'd0;
  localparam logic [1:0] MODE_LOAD_COL = 2'd1;
  localparam logic [1:0] MODE_FINISH   = 2'd2;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [IndexWidth-1:0]        entry_index;
    logic signed [ValueWidth-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SumWidth-1:0] dot_sum;
    logic                       is_nonzero;
    logic                       overflow;
  } out_item_t;

  typedef struct packed {
    logic [IndexWidth-1:0]        idx;
    logic signed [ValueWidth-1:0] val;
  } list_entry_t;

endpackage

### hdl/sparse_dot_product_intersect_core.sv
// ----------------------------------------------------------------------------
// sparse_dot_product_intersect_core
// dot product of a sparse row and a sparse column held as index/value lists
// ----------------------------------------------------------------------------
// A load item (row or column) leaves busy low. A finish item raises busy
// and walks both lists with two pointers, one step per cycle, since each
// step's compare feeds the next read address of the two list memories; the
// walk makes at most row count + column count - 1 pointer moves. The result
// is shown for exactly one cycle, the last busy one, with result_valid_o and
// must be taken then: there is no way to hold it off. Finish empties both
// lists and the drop flag. Loads beyond the list capacity are dropped and
// flagged; loads with an index at or above the index range are silently
// ignored.
module sparse_dot_product_intersect_core
  import spdot_pkg::*;
#(
  parameter int unsigned MaxEntries = DefMaxEntries,
  parameter int unsigned IndexRange = DefIndexRange
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      result_valid_o,
  output out_item_t result_o
);

  localparam int unsigned AddrWidth = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntWidth  = $clog2(MaxEntries + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_d, state_q;
  logic [CntWidth-1:0] row_cnt_d, row_cnt_q;
  logic [CntWidth-1:0] col_cnt_d, col_cnt_q;
  logic                dropped_d, dropped_q;
  logic [CntWidth-1:0] pa_d, pa_q;
  logic [CntWidth-1:0] pb_d, pb_q;

  logic        accept;
  logic        index_ok;
  logic        row_we, col_we;
  list_entry_t wentry;
  list_entry_t row_rd, col_rd;
  logic        both_live, idx_eq, idx_gt;
  logic        mac_clear, mac_en;
  logic signed [SumWidth-1:0] sum;

  assign accept   = start & ~busy;
  assign index_ok = 32'(item_i.entry_index) < 32'(IndexRange);
  assign wentry   = '{idx: item_i.entry_index, val: item_i.entry_value};

  assign row_we = accept && item_i.mode == MODE_LOAD_ROW && index_ok &&
                  row_cnt_q < CntWidth'(MaxEntries);
  assign col_we = accept && item_i.mode == MODE_LOAD_COL && index_ok &&
                  col_cnt_q < CntWidth'(MaxEntries);

  assign both_live = (pa_q < row_cnt_q) && (pb_q < col_cnt_q);
  assign idx_eq    = row_rd.idx == col_rd.idx;
  assign idx_gt    = row_rd.idx > col_rd.idx;

  always_comb begin
    state_d   = state_q;
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    dropped_d = dropped_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    mac_clear = 1'b0;
    mac_en    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pa_d = '0;
        pb_d = '0;
        if (accept) begin
          case (item_i.mode)
            MODE_LOAD_ROW: begin
              if (index_ok) begin
                if (row_we) row_cnt_d = row_cnt_q + 1'b1;
                else        dropped_d = 1'b1;
              end
            end
            MODE_LOAD_COL: begin
              if (index_ok) begin
                if (col_we) col_cnt_d = col_cnt_q + 1'b1;
                else        dropped_d = 1'b1;
              end
            end
            MODE_FINISH: begin
              mac_clear = 1'b1;
              state_d   = ST_WALK;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (both_live) begin
          mac_en = idx_eq;
          if (idx_eq || !idx_gt) pa_d = pa_q + 1'b1;
          if (idx_eq || idx_gt)  pb_d = pb_q + 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        row_cnt_d = '0;
        col_cnt_d = '0;
        dropped_d = 1'b0;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      dropped_q <= 1'b0;
      pa_q      <= '0;
      pb_q      <= '0;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      dropped_q <= dropped_d;
      pa_q      <= pa_d;
      pb_q      <= pb_d;
    end
  end

  // read address follows the next pointers so the read data matches the current pointers
  spdot_list_mem #(
    .Depth    (MaxEntries),
    .AddrWidth(AddrWidth)
  ) u_row_mem (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(row_cnt_q[AddrWidth-1:0]),
    .wdata_i(wentry),
    .raddr_i(pa_d[AddrWidth-1:0]),
    .rdata_o(row_rd)
  );

  spdot_list_mem #(
    .Depth    (MaxEntries),
    .AddrWidth(AddrWidth)
  ) u_col_mem (
    .clk_i  (clk_i),
    .we_i   (col_we),
    .waddr_i(col_cnt_q[AddrWidth-1:0]),
    .wdata_i(wentry),
    .raddr_i(pb_d[AddrWidth-1:0]),
    .rdata_o(col_rd)
  );

  spdot_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(mac_clear),
    .en_i   (mac_en),
    .a_i    (row_rd.val),
    .b_i    (col_rd.val),
    .sum_o  (sum)
  );

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = state_q == ST_EMIT;
  assign result_o       = '{dot_sum: sum, is_nonzero: (sum != '0), overflow: dropped_q};

endmodule

### hdl/spdot_list_mem.sv
// ----------------------------------------------------------------------------
// spdot_list_mem
// nonzero list buffer: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module spdot_list_mem
  import spdot_pkg::*;
#(
  parameter int unsigned Depth = DefMaxEntries,
  parameter int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  list_entry_t          wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output list_entry_t          rdata_o
);

  list_entry_t mem [Depth];
  list_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/spdot_mac.sv
// ----------------------------------------------------------------------------
// spdot_mac
// signed 32x32 multiply, product register, then 64-bit wrapping accumulate
// ----------------------------------------------------------------------------
module spdot_mac
  import spdot_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         en_i,
  input  logic signed [ValueWidth-1:0] a_i,
  input  logic signed [ValueWidth-1:0] b_i,
  output logic signed [SumWidth-1:0]   sum_o
);

  logic signed [SumWidth-1:0] prod_d, prod_q;
  logic                       prod_vld_q;
  logic signed [SumWidth-1:0] sum_d, sum_q;

  assign prod_d = SumWidth'(a_i) * SumWidth'(b_i);

  always_comb begin
    sum_d = sum_q;
    if (clear_i) begin
      sum_d = '0;
    end else if (prod_vld_q) begin
      sum_d = sum_q + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= en_i & ~clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for sparse_dot_product_intersect_core: a short table of
// directed items, then random row/column lists with finish items; results are
// checked against the table's typed values where given, else against an in-bench model of the two-pointer walk
// ----------------------------------------------------------------------------
module tb_top;
  import spdot_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned NumItems   = 1550;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 2 * DefMaxEntries + 16;

  // one row of the directed table: the item, plus a typed result for finish
  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  idx;
    logic [31:0] val;
    logic        known;
    logic [63:0] sum;
    logic        nonzero;
    logic        ovf;
  } dir_row_t;

  typedef struct packed {
    logic      valid;
    out_item_t res;
  } typed_sum_t;

  localparam int NumDirRows = 27;

  dir_row_t dir_rows [NumDirRows] = '{
    '{MODE_FINISH,   10'd0,    32'h0,          1'b1, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_ROW, 10'd5,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd5,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_FINISH,   10'd0,    32'h0,          1'b1, 64'h4000_0000_0000_0000, 1'b1, 1'b0},
    '{MODE_LOAD_ROW, 10'd1023, 32'h7FFF_FFFF,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd1023, 32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_UNUSED,   10'd1023, 32'hFFFF_FFFF,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_FINISH,   10'd0,    32'h0,          1'b1, 64'hC000_0000_8000_0000, 1'b1, 1'b0},
    // four max products add up to exactly 2^64 and wrap to zero
    '{MODE_LOAD_ROW, 10'd0,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd0,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_ROW, 10'd1,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd1,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_ROW, 10'd2,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd2,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_ROW, 10'd3,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd3,    32'h8000_0000,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_FINISH,   10'd0,    32'h0,          1'b1, 64'h0,                  1'b0, 1'b0},
    // row list loaded out of order
    '{MODE_LOAD_ROW, 10'd7,    32'd3,          1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_ROW, 10'd2,    32'd4,          1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd2,    32'd5,          1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd7,    32'hFFFF_FFFF,  1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_FINISH,   10'd0,    32'h0,          1'b0, 64'h0,                  1'b0, 1'b0},
    // empty row list
    '{MODE_LOAD_COL, 10'd9,    32'd100,        1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_FINISH,   10'd0,    32'h0,          1'b1, 64'h0,                  1'b0, 1'b0},
    // match with a zero value
    '{MODE_LOAD_ROW, 10'd0,    32'h0,          1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_LOAD_COL, 10'd0,    32'd1,          1'b0, 64'h0,                  1'b0, 1'b0},
    '{MODE_FINISH,   10'd0,    32'h0,          1'b1, 64'h0,                  1'b0, 1'b0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      result_valid;
  out_item_t result;

  // model state
  list_entry_t row_entries[$];
  list_entry_t col_entries[$];
  logic        drop_seen = 1'b0;

  out_item_t   pending_sums[$];
  typed_sum_t  typed_sums[$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned overflow_results = 0;
  int unsigned lists_run = 0;
  int unsigned longest_list = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;

  always #10 clk_i = ~clk_i;

  sparse_dot_product_intersect_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  // two-pointer walk over the loaded lists, then both lists and the flag clear
  function automatic out_item_t intersect_dot();
    out_item_t          r;
    logic signed [63:0] acc;
    int                 pa;
    int                 pb;
    acc = '0;
    pa = 0;
    pb = 0;
    while (pa < row_entries.size() && pb < col_entries.size()) begin
      if (row_entries[pa].idx == col_entries[pb].idx) begin
        acc += longint'($signed(row_entries[pa].val)) * longint'($signed(col_entries[pb].val));
        pa++;
        pb++;
      end else if (row_entries[pa].idx > col_entries[pb].idx) begin
        pb++;
      end else begin
        pa++;
      end
    end
    r.dot_sum    = acc;
    r.is_nonzero = (acc != 0);
    r.overflow   = drop_seen;
    if (row_entries.size() > longest_list) longest_list = row_entries.size();
    if (col_entries.size() > longest_list) longest_list = col_entries.size();
    row_entries.delete();
    col_entries.delete();
    drop_seen = 1'b0;
    return r;
  endfunction

  function automatic void track_item(input in_item_t it);
    list_entry_t e;
    out_item_t   predicted;
    typed_sum_t  typed;
    e.idx = it.entry_index;
    e.val = it.entry_value;
    case (it.mode)
      MODE_LOAD_ROW: begin
        if (it.entry_index < DefIndexRange) begin
          if (row_entries.size() >= DefMaxEntries) drop_seen = 1'b1;
          else row_entries.push_back(e);
        end
      end
      MODE_LOAD_COL: begin
        if (it.entry_index < DefIndexRange) begin
          if (col_entries.size() >= DefMaxEntries) drop_seen = 1'b1;
          else col_entries.push_back(e);
        end
      end
      MODE_FINISH: begin
        predicted = intersect_dot();
        typed = '0;
        if (typed_sums.size() != 0) typed = typed_sums.pop_front();
        pending_sums.push_back(typed.valid ? typed.res : predicted);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (pending_sums.size() == 0) begin
      $error("result with no finish waiting: dot_sum %h", got.dot_sum);
      errors++;
    end else begin
      want = pending_sums.pop_front();
      results_seen++;
      if (got.overflow) overflow_results++;
      if (got.dot_sum !== want.dot_sum) begin
        $error("dot_sum: expected %h, got %h", want.dot_sum, got.dot_sum);
        errors++;
      end
      if (got.is_nonzero !== want.is_nonzero) begin
        $error("is_nonzero: expected %b, got %b", want.is_nonzero, got.is_nonzero);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %b, got %b", want.overflow, got.overflow);
        errors++;
      end
    end
  endfunction

  // result first, so a finish taken at the same edge queues behind it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid) check_result(result);
      if (start && !busy) track_item(item);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_sums.size());
      $display("** sparse_dot_product_intersect_core: FAILED **");
      $finish;
    end
  end

  // drive one item and hold it until the transfer; start stays high after
  task automatic send_item(input in_item_t it, input logic known, input out_item_t known_res);
    typed_sum_t typed;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    if (it.mode == MODE_FINISH) begin
      typed.valid = known;
      typed.res   = known_res;
      typed_sums.push_back(typed);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
    if (it.mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_plain(input logic [1:0] mode, input logic [9:0] idx,
                            input logic [31:0] val);
    in_item_t it;
    it.mode        = mode;
    it.entry_index = idx;
    it.entry_value = val;
    send_item(it, 1'b0, '0);
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_sums.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // ascending walk over the index space; each position goes to both lists,
  // the row list or the column list, then extra loads past the walk, then finish
  task automatic run_lists(input int row_target, input int col_target, input int max_step,
                           input int extra_rows, input int extra_cols);
    int nr;
    int nc;
    int pos;
    int pick;
    nr = 0;
    nc = 0;
    pos = $urandom_range(0, 3);
    while (pos <= 1023 && (nr < row_target || nc < col_target)) begin
      pick = $urandom_range(0, 3);
      if ((pick == 0 || pick == 1 || pick == 3) && nr < row_target) begin
        send_plain(MODE_LOAD_ROW, pos[9:0], pick_value());
        nr++;
      end
      if ((pick == 0 || pick == 2 || pick == 3) && nc < col_target) begin
        send_plain(MODE_LOAD_COL, pos[9:0], pick_value());
        nc++;
      end
      pos += $urandom_range(1, max_step);
    end
    repeat (extra_rows) send_plain(MODE_LOAD_ROW, 10'($urandom), pick_value());
    repeat (extra_cols) send_plain(MODE_LOAD_COL, 10'($urandom), pick_value());
    send_plain(MODE_FINISH, 10'($urandom), $urandom);
    lists_run++;
  endtask

  // unordered loads on a narrow index range so matches still happen
  task automatic run_unordered();
    repeat ($urandom_range(1, 12)) begin
      send_plain($urandom_range(0, 1) ? MODE_LOAD_COL : MODE_LOAD_ROW,
                 10'($urandom_range(0, 15)), pick_value());
    end
    send_plain(MODE_FINISH, 10'($urandom), $urandom);
    lists_run++;
  endtask

  initial begin
    int          set_no;
    in_item_t    it;
    out_item_t   known_res;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      it.mode              = dir_rows[i].mode;
      it.entry_index       = dir_rows[i].idx;
      it.entry_value       = dir_rows[i].val;
      known_res.dot_sum    = dir_rows[i].sum;
      known_res.is_nonzero = dir_rows[i].nonzero;
      known_res.overflow   = dir_rows[i].ovf;
      send_item(it, dir_rows[i].known, known_res);
    end
    wait_results_done();

    set_no = 0;
    while (items_sent < NumItems) begin
      case (set_no)
        4:  run_lists(256, 256, 2, 2, 1);   // both lists full, then dropped loads
        20: run_lists(256, 3, 2, 0, 0);     // row list exactly full, nothing dropped
        default: begin
          case ($urandom_range(0, 9))
            0: begin
              repeat ($urandom_range(1, 4)) begin
                send_plain(2'($urandom_range(0, 3)), 10'($urandom), $urandom);
              end
            end
            1: run_unordered();
            default: run_lists($urandom_range(0, 8), $urandom_range(0, 8),
                               $urandom_range(1, 40), 0, 0);
          endcase
        end
      endcase
      if (set_no % 15 == 14) wait_results_done();
      set_no++;
    end

    wait_results_done();
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d items over %0d list pairs, checked %0d results", items_sent,
             lists_run, results_seen);
    $display("%0d results flagged dropped loads, longest list held %0d entries",
             overflow_results, longest_list);
    if (errors == 0) begin
      $display("** sparse_dot_product_intersect_core: PASSED **");
    end else begin
      $display("** sparse_dot_product_intersect_core: FAILED **");
    end
    $finish;
  end

endmodule
